// ===== rtl/core/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpi_pkg: trajectory point interpolator package
// types, status and action codes, table sizing
// ----------------------------------------------------------------------------
`default_nettype none
package tpi_pkg;
   localparam int MaxPoints = 64;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0, ACT_QUERY = 2'd1, ACT_CLEAR = 2'd2, ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_LOADED = 3'd0, ST_ANSWERED = 3'd1, ST_EMPTY = 3'd2, ST_FULL = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        time_q;
      logic signed [31:0] north_in;
      logic signed [31:0] east_in;
      logic signed [31:0] down_in;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] pos_north;
      logic signed [31:0] pos_east;
      logic signed [31:0] pos_down;
      logic signed [31:0] vel_north;
      logic signed [31:0] vel_east;
      logic signed [31:0] vel_down;
      logic [5:0]         nearest_index;
      logic               completed;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        neg;
      logic [65:0] num;
      logic [32:0] den;
   } div_req_type;
endpackage
`default_nettype wire

// ===== rtl/core/tpi_div.sv =====
// ----------------------------------------------------------------------------
// tpi_div: shared signed divider
// restoring radix-2 divide, one quotient bit per cycle, truncating, capped
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tpi_pkg::div_req_type dreq,
   output logic                   done,
   output logic signed [63:0]     quot
);
   import tpi_pkg::*;
   localparam logic [65:0] QuotCap = 66'h100_0000_0000;

   logic [65:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [32:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;
   logic [65:0] qc;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[65]} - {1'b0, d_ff};
      if (dreq.start) begin
         q_in = dreq.num; r_in = '0; d_in = dreq.den; n_in = 7'd66;
         neg_in = dreq.neg; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            r_in = trial[32:0];
            q_in = {q_ff[64:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[65]};
            q_in = {q_ff[64:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign qc   = (q_ff > QuotCap) ? QuotCap : q_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, qc[62:0]}) : $signed({1'b0, qc[62:0]});
endmodule
`default_nettype wire

// ===== rtl/core/trajectory_point_interpolator.sv =====
// ----------------------------------------------------------------------------
// trajectory_point_interpolator: piecewise linear trajectory interpolation
// point table, nearest-time scan and per-axis interpolation on one divider
// ----------------------------------------------------------------------------
// channel  direction  ports                   transfer
// req      in         start, busy, req_data   start high while busy low
// rsp      out        rsp_valid, rsp_data     one cycle strobe, no back pressure
//
// load, clear, query of an empty table: no scan or divide, only the output state, which raises the result strobe.
// query: the scan reads the table (one table read per cycle), then the block picks
// the segment, reads its ends, runs 6 divides one after another on the shared
// divider, finishes and strobes; equal segment times skip the divides.
// reset empties the table; contents stay undefined.
// busy is high from the transfer until the result strobe.
`default_nettype none
module trajectory_point_interpolator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tpi_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output tpi_pkg::rsp_type       rsp_data
);
   import tpi_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001, S_SCAN = 11'b00000000010, S_SWAIT = 11'b00000000100,
      S_PICK = 11'b00000001000, S_RDA  = 11'b00000010000, S_RDB  = 11'b00000100000,
      S_LATB = 11'b00001000000, S_DIV  = 11'b00010000000, S_DWAIT = 11'b00100000000,
      S_FIN  = 11'b01000000000, S_OUT  = 11'b10000000000
   } state_type;

   logic [31:0] mem_t [MaxPoints];
   logic [31:0] mem_n [MaxPoints];
   logic [31:0] mem_e [MaxPoints];
   logic [31:0] mem_d [MaxPoints];

   state_type   st_ff, st_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   req_type     rq_ff, rq_in;
   rsp_type     rs_ff, rs_in;
   logic        val_ff, val_in;
   logic [IdxW-1:0] ra_ff, ra_in;
   logic [31:0] rt_ff, rn_ff, re_ff, rd_ff;
   logic        we;
   logic [CntW-1:0] sc_ff, sc_in;
   logic        rv_ff, rv_in;
   logic [IdxW-1:0] ri_ff, ri_in;
   logic        rv2_ff, rv2_in;
   logic [IdxW-1:0] ri2_ff, ri2_in;
   logic [IdxW-1:0] best_ff, best_in;
   logic [31:0] bd_ff, bd_in, tb_ff, tb_in;
   logic [31:0] tl_ff, tl_in;
   logic        edge_ff, edge_in;
   logic [IdxW-1:0] ia_ff, ia_in;
   logic signed [32:0] t0_ff, t0_in, t1_ff, t1_in;
   logic signed [32:0] p0_ff [3];
   logic signed [32:0] p0_in [3];
   logic signed [32:0] dp_ff [3];
   logic signed [32:0] dp_in [3];
   logic [2:0]  k_ff, k_in;
   logic signed [63:0] res_ff [6];
   logic signed [63:0] res_in [6];
   logic signed [65:0] prod;
   logic signed [32:0] span;
   div_req_type dreq;
   logic        ddone;
   logic signed [63:0] dq;
   logic [31:0] gap;
   logic signed [32:0] mulb;
   logic signed [32:0] dpk;

   tpi_div u_div (.clock(clock), .reset(reset), .dreq(dreq), .done(ddone), .quot(dq));

   function automatic logic [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (we) begin
         mem_t[cnt_ff[IdxW-1:0]] <= rq_ff.time_q;
         mem_n[cnt_ff[IdxW-1:0]] <= rq_ff.north_in;
         mem_e[cnt_ff[IdxW-1:0]] <= rq_ff.east_in;
         mem_d[cnt_ff[IdxW-1:0]] <= rq_ff.down_in;
      end
      rt_ff <= mem_t[ra_ff]; rn_ff <= mem_n[ra_ff];
      re_ff <= mem_e[ra_ff]; rd_ff <= mem_d[ra_ff];
   end

   assign gap  = (rt_ff >= rq_ff.time_q) ? rt_ff - rq_ff.time_q : rq_ff.time_q - rt_ff;
   assign dpk  = dp_ff[k_ff[1:0]];
   assign mulb = k_ff[2] ? 33'sd65536 : $signed({1'b0, rq_ff.time_q}) - t0_ff;
   assign prod = dpk * mulb;
   assign span = t1_ff - t0_ff;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; rq_in = rq_ff; rs_in = rs_ff; val_in = 1'b0;
      ra_in = ra_ff; we = 1'b0; sc_in = sc_ff; rv_in = 1'b0; ri_in = ri_ff;
      rv2_in = rv_ff; ri2_in = ri_ff;
      best_in = best_ff; bd_in = bd_ff; tb_in = tb_ff; tl_in = tl_ff;
      edge_in = edge_ff; ia_in = ia_ff; t0_in = t0_ff; t1_in = t1_ff;
      p0_in = p0_ff; dp_in = dp_ff; k_in = k_ff; res_in = res_ff;
      dreq = '0;
      case (st_ff)
         S_IDLE: if (start) begin
            rq_in = req_data;
            rs_in = '0;
            case (action_type'(req_data.action))
               ACT_CLEAR: begin
                  cnt_in = '0; rs_in.status = ST_CLEARED; st_in = S_OUT;
               end
               ACT_LOAD: begin
                  rs_in.status = (cnt_ff >= CntW'(MaxPoints)) ? ST_FULL : ST_LOADED;
                  st_in = S_OUT;
               end
               ACT_QUERY: begin
                  if (cnt_ff == '0) begin
                     rs_in.status = ST_EMPTY; rs_in.completed = 1'b1; st_in = S_OUT;
                  end else begin
                     sc_in = '0; st_in = S_SCAN;
                  end
               end
               default: st_in = S_IDLE;
            endcase
            if (action_type'(req_data.action) == ACT_NONE) st_in = S_IDLE;
         end
         S_SCAN: begin
            if (sc_ff < cnt_ff) begin
               ra_in = sc_ff[IdxW-1:0]; rv_in = 1'b1; ri_in = sc_ff[IdxW-1:0];
               sc_in = sc_ff + 1'b1;
            end else st_in = S_SWAIT;
         end
         S_SWAIT: st_in = S_PICK;
         S_PICK: begin
            edge_in = (best_ff == '0) ||
               (rq_ff.time_q >= tb_ff && ({1'b0, best_ff} + 1'b1) >= cnt_ff);
            if (rq_ff.time_q < tb_ff) ia_in = best_ff - 1'b1;
            else ia_in = best_ff;
            ra_in = (rq_ff.time_q < tb_ff) ? best_ff - 1'b1 : best_ff;
            st_in = S_RDA;
         end
         S_RDA: begin
            ra_in = ia_ff + 1'b1; st_in = S_RDB;
         end
         S_RDB: begin
            t0_in = $signed({1'b0, rt_ff});
            p0_in[0] = $signed({rn_ff[31], rn_ff});
            p0_in[1] = $signed({re_ff[31], re_ff});
            p0_in[2] = $signed({rd_ff[31], rd_ff});
            st_in = S_LATB;
         end
         S_LATB: begin
            t1_in = $signed({1'b0, rt_ff});
            dp_in[0] = $signed({rn_ff[31], rn_ff}) - p0_ff[0];
            dp_in[1] = $signed({re_ff[31], re_ff}) - p0_ff[1];
            dp_in[2] = $signed({rd_ff[31], rd_ff}) - p0_ff[2];
            if (edge_ff) begin
               t0_in = '0; t1_in = 33'sd65536;
               dp_in[0] = '0; dp_in[1] = '0; dp_in[2] = '0;
               if (best_ff != ia_ff) begin
                  p0_in[0] = $signed({rn_ff[31], rn_ff});
                  p0_in[1] = $signed({re_ff[31], re_ff});
                  p0_in[2] = $signed({rd_ff[31], rd_ff});
               end
            end
            k_in = 3'd0; st_in = S_DIV;
         end
         S_DIV: begin
            if (span == '0) begin
               res_in[0] = '0; res_in[1] = '0; res_in[2] = '0;
               res_in[3] = '0; res_in[4] = '0; res_in[5] = '0;
               st_in = S_FIN;
            end else begin
               st_in = S_DWAIT;
               dreq.start = 1'b1;
               dreq.neg = (prod < 0) ^ (span < 0);
               dreq.num = (prod < 0) ? -prod : prod;
               dreq.den = (span < 0) ? -span : span;
            end
         end
         // slots 0..2 position, 4..6 velocity into results 3..5
         S_DWAIT: if (ddone) begin
            res_in[3'(k_ff - {2'b00, k_ff[2]})] = dq;
            if (k_ff == 3'd6) st_in = S_FIN;
            else begin
               k_in = (k_ff == 3'd2) ? 3'd4 : k_ff + 3'd1;
               st_in = S_DIV;
            end
         end
         S_FIN: begin
            rs_in.status = ST_ANSWERED;
            rs_in.pos_north = sat(64'(p0_ff[0]) + res_ff[0]);
            rs_in.pos_east  = sat(64'(p0_ff[1]) + res_ff[1]);
            rs_in.pos_down  = sat(64'(p0_ff[2]) + res_ff[2]);
            rs_in.vel_north = sat(res_ff[3]);
            rs_in.vel_east  = sat(res_ff[4]);
            rs_in.vel_down  = sat(res_ff[5]);
            rs_in.nearest_index = 6'(best_ff);
            rs_in.completed = rq_ff.time_q > tl_ff;
            st_in = S_OUT;
         end
         S_OUT: begin
            if (rq_ff.action == ACT_LOAD && rs_ff.status == ST_LOADED) begin
               we = 1'b1; cnt_in = cnt_ff + 1'b1;
            end
            val_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (rv2_ff) begin
         if (ri2_ff == '0 || gap < bd_ff) begin
            bd_in = gap; best_in = ri2_ff; tb_in = rt_ff;
         end
         tl_in = rt_ff;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in; rs_ff <= rs_in; ra_ff <= ra_in; sc_ff <= sc_in; ri_ff <= ri_in;
      ri2_ff <= ri2_in;
      best_ff <= best_in; bd_ff <= bd_in; tb_ff <= tb_in; tl_ff <= tl_in;
      edge_ff <= edge_in; ia_ff <= ia_in; t0_ff <= t0_in; t1_ff <= t1_in;
      p0_ff <= p0_in; dp_ff <= dp_in;
      k_ff <= k_in;
      for (int i = 0; i < 6; i++) res_ff[i] <= res_in[i];
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; val_ff <= 1'b0; rv_ff <= 1'b0; rv2_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; val_ff <= val_in; rv_ff <= rv_in;
         rv2_ff <= rv2_in;
      end
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = val_ff;
   assign rsp_data  = rs_ff;
endmodule
`default_nettype wire

// ===== rtl/core/tpi_checker.sv =====
// ----------------------------------------------------------------------------
// tpi_assertions: port-level checks on the trajectory point interpolator
// status codes, transfer and strobe ordering
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_assertions (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire tpi_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire tpi_pkg::rsp_type rsp_data
);
   import tpi_pkg::*;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action != ACT_NONE |=> busy)
      else $error("no busy after transfer");
   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("strobe longer than one cycle");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_CLEARED)
      else $error("bad status");
   a_empty_completed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.completed)
      else $error("empty without completed");
endmodule

bind trajectory_point_interpolator tpi_assertions u_tpi_assertions (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
`default_nettype wire

// ===== tb/tpi_checker.sv =====
// ----------------------------------------------------------------------------
// tpi_checker: trajectory point interpolator checker
// watches request and response transfers, keeps its own point table and
// predicts every response, compares the whole response against the oldest one
// ----------------------------------------------------------------------------
`default_nettype none
module tpi_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire tpi_pkg::req_type  req_data,
   input  wire logic              rsp_valid,
   input  wire tpi_pkg::rsp_type  rsp_data,
   output int                     errors,
   output int                     pending
);
   import tpi_pkg::*;

   logic [31:0]        tbl_time [MaxPoints];
   logic signed [63:0] tbl_pos  [MaxPoints][3];
   int                 tbl_count;
   rsp_type            expected_rsp [$];

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] scaled_ratio(input logic signed [63:0] a,
         input logic signed [63:0] b, input logic signed [63:0] d);
      logic        neg;
      logic [63:0] ua, ub, ud, q;
      neg = (a < 0) ^ (b < 0) ^ (d < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      ud = (d < 0) ? -d : d;
      q = (ua * ub) / ud;
      if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic rsp_type answer_query(input logic [31:0] tq);
      rsp_type            r;
      int                 best, lo, hi;
      logic [31:0]        bestd, d;
      logic signed [63:0] t0, t1, dt, dp, p, v;
      r = '0;
      best = 0;
      bestd = '1;
      for (int i = 0; i < tbl_count; i++) begin
         d = (tbl_time[i] >= tq) ? tbl_time[i] - tq : tq - tbl_time[i];
         if (i == 0 || d < bestd) begin
            bestd = d;
            best = i;
         end
      end
      if (best == 0 || (tq >= tbl_time[best] && best + 1 >= tbl_count)) begin
         lo = best; hi = best; t0 = 0; t1 = 65536;
      end else if (tq < tbl_time[best]) begin
         lo = best - 1; hi = best;
         t0 = tbl_time[lo]; t1 = tbl_time[hi];
      end else begin
         lo = best; hi = best + 1;
         t0 = tbl_time[lo]; t1 = tbl_time[hi];
      end
      dt = t1 - t0;
      for (int k = 0; k < 3; k++) begin
         dp = tbl_pos[hi][k] - tbl_pos[lo][k];
         p = tbl_pos[lo][k];
         v = 0;
         if (dt != 0) begin
            p = clamp32(tbl_pos[lo][k] + scaled_ratio(dp, $signed({32'd0, tq}) - t0, dt));
            v = clamp32(scaled_ratio(dp, 64'sd65536, dt));
         end
         case (k)
            0: begin r.pos_north = p[31:0]; r.vel_north = v[31:0]; end
            1: begin r.pos_east = p[31:0]; r.vel_east = v[31:0]; end
            default: begin r.pos_down = p[31:0]; r.vel_down = v[31:0]; end
         endcase
      end
      r.status = ST_ANSWERED;
      r.nearest_index = best[5:0];
      r.completed = tq > tbl_time[tbl_count - 1];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type r;
      rsp_type want;
      if (reset) begin
         tbl_count = 0;
         errors <= 0;
         pending <= 0;
         expected_rsp.delete();
      end else begin
         if (start && !busy && req_data.action != ACT_NONE) begin
            r = '0;
            case (action_type'(req_data.action))
               ACT_CLEAR: begin
                  tbl_count = 0;
                  r.status = ST_CLEARED;
               end
               ACT_LOAD: begin
                  if (tbl_count >= MaxPoints) r.status = ST_FULL;
                  else begin
                     tbl_time[tbl_count] = req_data.time_q;
                     tbl_pos[tbl_count][0] = req_data.north_in;
                     tbl_pos[tbl_count][1] = req_data.east_in;
                     tbl_pos[tbl_count][2] = req_data.down_in;
                     tbl_count = tbl_count + 1;
                     r.status = ST_LOADED;
                  end
               end
               default: begin
                  if (tbl_count == 0) begin
                     r.status = ST_EMPTY;
                     r.completed = 1'b1;
                  end else r = answer_query(req_data.time_q);
               end
            endcase
            expected_rsp = {expected_rsp, r};
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               if (errors < 10) $display("checker: response with none expected %p", rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data !== want) begin
                  if (errors < 10)
                     $display("checker: mismatch expected %p actual %p", want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         pending <= expected_rsp.size();
      end
   end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: trajectory point interpolator testbench
// directed loads, queries and clears, then random trajectories with noise,
// bursty requests; the checker predicts and compares every response
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
   import tpi_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy, rsp_valid;
   rsp_type rsp_data;
   int      errors, pending;
   int      idle_cycles = 0;
   logic [31:0] last_time;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   trajectory_point_interpolator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   tpi_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .errors(errors), .pending(pending)
   );

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      endcase
   endfunction

   task automatic send(input action_type act, input logic [31:0] t,
         input logic [31:0] n, input logic [31:0] e, input logic [31:0] d);
      start = 1'b1;
      req_data = '{action: act, time_q: t, north_in: n, east_in: e, down_in: d};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
      if (act == ACT_LOAD) last_time = t;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
   endtask

   task automatic query_any();
      case ($urandom_range(0, 3))
         0: send(ACT_QUERY, $urandom, $urandom, $urandom, $urandom);
         1: send(ACT_QUERY, last_time + $urandom_range(0, 3), 0, 0, 0);
         default: send(ACT_QUERY, $urandom_range(0, last_time + 32'h1000), 0, 0, 0);
      endcase
   endtask

   initial begin
      int npts, burst;
      logic [31:0] t;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      send(ACT_QUERY, 32'h0, 0, 0, 0);
      send(ACT_LOAD, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send(ACT_QUERY, 32'h0, 0, 0, 0);
      send(ACT_QUERY, 32'hffff_ffff, 0, 0, 0);
      send(ACT_LOAD, 32'h0001_0000, 32'h0, 32'h0, 32'hffff_ffff);
      send(ACT_LOAD, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0010_0000);
      send(ACT_LOAD, 32'h0002_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
      send(ACT_QUERY, 32'h0001_0000, 0, 0, 0);
      send(ACT_QUERY, 32'h0001_8000, 0, 0, 0);
      send(ACT_QUERY, 32'h0001_c000, 0, 0, 0);
      send(ACT_QUERY, 32'h0002_0001, 0, 0, 0);
      send(ACT_QUERY, 32'h0002_0000, 0, 0, 0);
      send(ACT_QUERY, 32'hffff_ffff, 0, 0, 0);
      send(ACT_NONE, 32'h1, 32'h1, 32'h1, 32'h1);
      send(ACT_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < MaxPoints + 1; i++)
         send(ACT_LOAD, i * 32'h0400_0000, rand_pos(), rand_pos(), rand_pos());
      send(ACT_QUERY, 32'hfc00_0001, 0, 0, 0);
      send(ACT_QUERY, 32'h0600_0000, 0, 0, 0);
      drain();
      // random trajectories
      for (int traj = 0; traj < 34; traj++) begin
         send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
         npts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MaxPoints)
                                            : $urandom_range(1, 6);
         t = $urandom_range(0, 32'h0100_0000);
         for (int i = 0; i < npts; i++) begin
            send(ACT_LOAD, t, rand_pos(), rand_pos(), rand_pos());
            if ($urandom_range(0, 4) != 0) t = t + $urandom_range(0, 32'h0008_0000);
         end
         burst = 0;
         for (int q = 0; q < 10; q++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 6);
               repeat ($urandom_range(0, 4)) @(negedge clock);
            end
            burst--;
            case ($urandom_range(0, 15))
               0: send(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
               1: send(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
               default: query_any();
            endcase
         end
         if (traj % 8 == 0) drain();
      end
      drain();
      repeat (600) @(posedge clock);
      if (errors == 0 && pending == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/tpi_pkg.sv
rtl/core/tpi_div.sv
rtl/core/trajectory_point_interpolator.sv
rtl/core/tpi_checker.sv
tb/tpi_checker.sv
tb/tb.sv
